// ===== hdl/assert_macros.svh =====
// assertion macros for the rtl files, included by the queue top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked on every clock edge outside reset
`define BHQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every clock edge, reset included
`define BHQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define BHQ_ASSERT(lbl, prop, msg)
`define BHQ_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== hdl/bhq_pkg.sv =====
package bhq_pkg;

  // fixed widths of the channel fields
  localparam int unsigned KeyInW  = 32;
  localparam int unsigned KeyOutW = 32;
  localparam int unsigned CntOutW = 7;

  // request kinds
  typedef enum logic {
    REQ_ENQ = 1'b0,
    REQ_DEQ = 1'b1
  } req_e;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

endpackage

// ===== hdl/bhq_if.sv =====
// request channel
interface bhq_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [bhq_pkg::KeyInW-1:0]  key_in;

  modport source (output valid, output req_type, output key_in, input ready);
  modport sink   (input valid, input req_type, input key_in, output ready);
endinterface

// result channel
interface bhq_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [bhq_pkg::KeyOutW-1:0] key_out;
  logic [1:0]                  status;
  logic [bhq_pkg::CntOutW-1:0] entry_count;

  modport source (output valid, output key_out, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input key_out, input status, input entry_count,
                  output ready);
endinterface

// ===== hdl/bhq_mem.sv =====
module bhq_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  // one write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // two registered read ports
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== hdl/binary_max_heap_queue_top.sv =====
// binary max-heap priority queue
//
// req_i carries one word per request: req_type selects enqueue of key_in
// or dequeue of the largest key held. rsp_o gives exactly one word per
// request: key_out (the removed key on a good dequeue, else zero), status
// (ok, dequeue on empty, enqueue on full) and entry_count after the request.
// A rejected request leaves the heap as it was.
//
// Keys live in a two-read, one-write memory with registered read ports.
// The moving key is held in a register and the hole walks one tree level
// per cycle, over at most log2(CAPACITY) levels. One request is worked on
// at a time; req_i.ready is high while the engine is free.
//
// The result sits in an output register, so a stalled receiver still lets
// the next request in; the engine waits only if it finishes while the
// previous result is still held. Reset empties the queue at once: no
// memory clearing pass is needed, only entries below the count are used.
`include "assert_macros.svh"

module binary_max_heap_queue_top #(
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bhq_req_if.sink    req_i,
  bhq_rsp_if.source  rsp_o
);

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned ChW  = IdxW + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_DN_LOAD,
    S_DN,
    S_RESP
  } state_e;

  state_e                state_q, state_d;
  logic [IdxW-1:0]       pos_q, pos_d;
  logic [KEY_WIDTH-1:0]  key_q, key_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [KEY_WIDTH-1:0]  res_key_q, res_key_d;
  bhq_pkg::status_e      res_st_q, res_st_d;

  logic                        out_valid_q, out_valid_d;
  logic [bhq_pkg::KeyOutW-1:0] out_key_q, out_key_d;
  bhq_pkg::status_e            out_st_q, out_st_d;
  logic [bhq_pkg::CntOutW-1:0] out_cnt_q, out_cnt_d;

  // memory ports
  logic                 we;
  logic [IdxW-1:0]      waddr, raddr_a, raddr_b;
  logic [KEY_WIDTH-1:0] wdata, rdata_a, rdata_b;

  // width adaption of keys and count
  logic [KEY_WIDTH+bhq_pkg::KeyInW-1:0]  key_in_ext;
  logic [KEY_WIDTH+bhq_pkg::KeyOutW-1:0] key_out_ext;
  logic [CntW+bhq_pkg::CntOutW-1:0]      cnt_out_ext;
  logic [ChW-1:0]                        cnt_ch;

  // tree walk helpers
  logic [IdxW-1:0]      par;
  logic [ChW-1:0]       lc, rc;
  logic                 lc_ok, rc_ok;
  logic                 take_lc, take_rc;
  logic [KEY_WIDTH-1:0] lc_max;
  logic                 rsp_free;

  function automatic logic [IdxW-1:0] parent_of(input logic [IdxW-1:0] p);
    logic [IdxW-1:0] pm1;
    pm1 = p - IdxW'(1);
    return pm1 >> 1;
  endfunction

  function automatic logic [IdxW-1:0] left_of(input logic [IdxW-1:0] p);
    logic [IdxW+1:0] t;
    t = {1'b0, p, 1'b1};
    return t[IdxW-1:0];
  endfunction

  function automatic logic [IdxW-1:0] right_of(input logic [IdxW-1:0] p);
    logic [IdxW+1:0] t;
    t = {1'b0, p, 1'b1} + (IdxW + 2)'(1);
    return t[IdxW-1:0];
  endfunction

  assign key_in_ext  = {{KEY_WIDTH{1'b0}}, req_i.key_in};
  assign key_out_ext = {{bhq_pkg::KeyOutW{1'b0}}, res_key_q};
  assign cnt_out_ext = {{bhq_pkg::CntOutW{1'b0}}, cnt_q};
  assign cnt_ch      = ChW'(cnt_q);

  // children of the current hole and which one wins
  assign par     = parent_of(pos_q);
  assign lc      = {1'b0, pos_q, 1'b1};
  assign rc      = lc + ChW'(1);
  assign lc_ok   = lc < cnt_ch;
  assign rc_ok   = rc < cnt_ch;
  assign take_lc = lc_ok && (rdata_a > key_q);
  assign lc_max  = take_lc ? rdata_a : key_q;
  assign take_rc = rc_ok && (rdata_b > lc_max);

  assign rsp_free = !out_valid_q || rsp_o.ready;

  // next state, memory accesses and result
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    key_d       = key_q;
    cnt_d       = cnt_q;
    res_key_d   = res_key_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q;
    out_key_d   = out_key_q;
    out_st_d    = out_st_q;
    out_cnt_d   = out_cnt_q;
    we          = 1'b0;
    waddr       = pos_q;
    wdata       = key_q;
    raddr_a     = '0;
    raddr_b     = '0;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          res_key_d = '0;
          res_st_d  = bhq_pkg::STATUS_OK;
          if (req_i.req_type == bhq_pkg::REQ_ENQ) begin
            if (cnt_q == CntW'(CAPACITY)) begin
              res_st_d = bhq_pkg::STATUS_FULL;
              state_d  = S_RESP;
            end else begin
              key_d   = key_in_ext[KEY_WIDTH-1:0];
              pos_d   = cnt_q[IdxW-1:0];
              cnt_d   = cnt_q + CntW'(1);
              raddr_a = parent_of(cnt_q[IdxW-1:0]);
              state_d = S_UP;
            end
          end else begin
            if (cnt_q == '0) begin
              res_st_d = bhq_pkg::STATUS_EMPTY;
              state_d  = S_RESP;
            end else begin
              cnt_d   = cnt_q - CntW'(1);
              raddr_a = '0;
              raddr_b = cnt_d[IdxW-1:0];
              state_d = S_DN_LOAD;
            end
          end
        end
      end

      // hole moves up while the key beats its parent
      S_UP: begin
        we = 1'b1;
        if (pos_q == '0 || !(key_q > rdata_a)) begin
          wdata   = key_q;
          state_d = S_RESP;
        end else begin
          wdata   = rdata_a;
          pos_d   = par;
          raddr_a = parent_of(par);
        end
      end

      // root goes out, last entry becomes the moving key
      S_DN_LOAD: begin
        res_key_d = rdata_a;
        key_d     = rdata_b;
        pos_d     = '0;
        if (cnt_q == '0) begin
          state_d = S_RESP;
        end else begin
          raddr_a = left_of('0);
          raddr_b = right_of('0);
          state_d = S_DN;
        end
      end

      // hole moves down toward the larger child
      S_DN: begin
        we = 1'b1;
        priority if (take_rc) begin
          wdata   = rdata_b;
          pos_d   = rc[IdxW-1:0];
          raddr_a = left_of(rc[IdxW-1:0]);
          raddr_b = right_of(rc[IdxW-1:0]);
        end else if (take_lc) begin
          wdata   = rdata_a;
          pos_d   = lc[IdxW-1:0];
          raddr_a = left_of(lc[IdxW-1:0]);
          raddr_b = right_of(lc[IdxW-1:0]);
        end else begin
          wdata   = key_q;
          state_d = S_RESP;
        end
      end

      // hand the result word to the output register
      S_RESP: begin
        if (rsp_free) begin
          out_valid_d = 1'b1;
          out_key_d   = key_out_ext[bhq_pkg::KeyOutW-1:0];
          out_st_d    = res_st_q;
          out_cnt_d   = cnt_out_ext[bhq_pkg::CntOutW-1:0];
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    key_q     <= key_d;
    res_key_q <= res_key_d;
    res_st_q  <= res_st_d;
    out_key_q <= out_key_d;
    out_st_q  <= out_st_d;
    out_cnt_q <= out_cnt_d;
  end

  bhq_mem #(
    .Depth (CAPACITY),
    .Width (KEY_WIDTH)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.key_out     = out_key_q;
  assign rsp_o.status      = out_st_q;
  assign rsp_o.entry_count = out_cnt_q;

  // checks
  `BHQ_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CntW'(CAPACITY), "entry count above capacity")
  `BHQ_ASSERT(a_busy_after_accept, req_i.valid && req_i.ready |=> !req_i.ready, "accept while busy")
  `BHQ_ASSERT(a_empty_zero_key, out_valid_q && out_st_q == bhq_pkg::STATUS_EMPTY |-> out_key_q == '0, "key on empty")
  `BHQ_ASSERT(a_up_in_range, state_q == S_UP |-> CntW'(pos_q) < cnt_q, "sift up outside heap")

endmodule
